>>> hw/rtl/shi_pkg.sv
// ----------------------------------------------------------------------------
// shi_pkg
// Shared types and constants for the segment / hyperplane intersection core.
// ----------------------------------------------------------------------------
package shi_pkg;

    localparam int NUM_LANES    = 4;
    localparam int COORD_W      = 32;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int SIDE_W       = PROD_W + 4;
    localparam int MAG_W        = SIDE_W;
    localparam int DELTA_W      = COORD_W + 1;
    localparam int QUO_W        = DELTA_W;
    localparam int DIV_STEPS    = QUO_W;
    localparam int MERGE_STAGES = 3;
    localparam int PIPE_DEPTH   = 1 + MERGE_STAGES + DIV_STEPS;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_A = 3'd0,
        REG_PLANE_B = 3'd1,
        REG_PLANE_C = 3'd2,
        REG_PLANE_D = 3'd3,
        REG_PLANE_E = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] start_w;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] end_w;
    } in_item_t;

    typedef struct packed {
        logic                      crosses;
        logic                      degenerate;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
        logic signed [COORD_W-1:0] cross_z;
        logic signed [COORD_W-1:0] cross_w;
    } out_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] start_prod;
        logic signed [PROD_W-1:0] end_prod;
    } side_prod_t;

    typedef struct packed {
        logic [DELTA_W-1:0]        mag;
        logic                      neg;
        logic signed [COORD_W-1:0] start;
    } seg_delta_t;

    typedef struct packed {
        logic crosses;
        logic degenerate;
    } cross_flags_t;

    typedef struct packed {
        logic [MAG_W-1:0] m1;
        logic [MAG_W-1:0] den;
    } div_ctl_t;

endpackage

>>> hw/rtl/shi_side_lane.sv
// ----------------------------------------------------------------------------
// shi_side_lane
// One coordinate lane: plane coefficient products for both endpoints and the
// endpoint difference, aligned to the merge stage output.
// ----------------------------------------------------------------------------
module shi_side_lane
    import shi_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coef,
    input  logic signed [COORD_W-1:0] p_start,
    input  logic signed [COORD_W-1:0] p_end,
    output side_prod_t                prod,
    output seg_delta_t                delta
);

    side_prod_t                prod_reg;
    seg_delta_t                dly_reg [MERGE_STAGES+1];
    seg_delta_t                delta_next;
    logic signed [DELTA_W-1:0] diff;

    always_comb
    begin
        diff             = DELTA_W'(p_end) - DELTA_W'(p_start);
        delta_next.neg   = diff[DELTA_W-1];
        delta_next.mag   = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
        delta_next.start = p_start;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg.start_prod <= PROD_W'(coef) * PROD_W'(p_start);
            prod_reg.end_prod   <= PROD_W'(coef) * PROD_W'(p_end);
            dly_reg[0]          <= delta_next;
            for (int k = 1; k <= MERGE_STAGES; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign prod  = prod_reg;
    assign delta = dly_reg[MERGE_STAGES];

endmodule

>>> hw/rtl/shi_plane_merge.sv
// ----------------------------------------------------------------------------
// shi_plane_merge
// Sums the lane products into the two side values and classifies the segment:
// crossing, degenerate, start magnitude and divisor.
// ----------------------------------------------------------------------------
module shi_plane_merge
    import shi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      en,
    input  side_prod_t                prod [NUM_LANES],
    input  logic signed [COORD_W-1:0] plane_e,
    output cross_flags_t              flags,
    output div_ctl_t                  ctl
);

    localparam int HALF = NUM_LANES / 2;

    logic signed [SIDE_W-1:0] s1_half_reg [2];
    logic signed [SIDE_W-1:0] s2_half_reg [2];
    logic signed [SIDE_W-1:0] eterm_reg;
    logic signed [SIDE_W-1:0] s1_reg;
    logic signed [SIDE_W-1:0] s2_reg;
    logic signed [SIDE_W-1:0] s1_half_next [2];
    logic signed [SIDE_W-1:0] s2_half_next [2];
    cross_flags_t             flags_reg;
    cross_flags_t             flags_next;
    div_ctl_t                 ctl_reg;
    div_ctl_t                 ctl_next;
    logic [MAG_W-1:0]         m2;
    logic                     side1;
    logic                     side2;

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            s1_half_next[h] = '0;
            s2_half_next[h] = '0;
            for (int k = 0; k < HALF; k++)
            begin
                s1_half_next[h] = s1_half_next[h] + SIDE_W'(prod[h*HALF+k].start_prod);
                s2_half_next[h] = s2_half_next[h] + SIDE_W'(prod[h*HALF+k].end_prod);
            end
        end
    end

    always_comb
    begin
        side1       = !s1_reg[SIDE_W-1];
        side2       = !s2_reg[SIDE_W-1] && (s2_reg != '0);
        ctl_next.m1 = s1_reg[SIDE_W-1] ? MAG_W'(-s1_reg) : MAG_W'(s1_reg);
        m2          = s2_reg[SIDE_W-1] ? MAG_W'(-s2_reg) : MAG_W'(s2_reg);
        ctl_next.den          = ctl_next.m1 + m2;
        flags_next.crosses    = side1 != side2;
        flags_next.degenerate = (side1 != side2) && (ctl_next.den == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_half_reg <= s1_half_next;
            s2_half_reg <= s2_half_next;
            eterm_reg   <= SIDE_W'(plane_e) <<< FRAC_BITS;
            s1_reg      <= s1_half_reg[0] + s1_half_reg[1] + eterm_reg;
            s2_reg      <= s2_half_reg[0] + s2_half_reg[1] + eterm_reg;
            flags_reg   <= flags_next;
            ctl_reg     <= ctl_next;
        end
    end

    assign flags = flags_reg;
    assign ctl   = ctl_reg;

endmodule

>>> hw/rtl/shi_div_lane.sv
// ----------------------------------------------------------------------------
// shi_div_lane
// Pipelined scaled division for one coordinate: |delta| * m1 / den taken one
// bit of |delta| per stage, then signed offset, add to start and saturate.
// ----------------------------------------------------------------------------
module shi_div_lane
    import shi_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  seg_delta_t                delta,
    input  div_ctl_t                  ctl,
    output logic signed [COORD_W-1:0] coord,
    output logic signed [COORD_W-1:0] start
);

    localparam int RES_W = QUO_W + 2;
    localparam logic signed [RES_W-1:0] SAT_HI =
        {{(RES_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_LO =
        {{(RES_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic [MAG_W-1:0] r;
    } div_state_t;

    div_state_t                st_reg    [DIV_STEPS];
    logic [DELTA_W-1:0]        bits_reg  [DIV_STEPS];
    div_ctl_t                  ctl_reg   [DIV_STEPS];
    logic                      neg_reg   [DIV_STEPS];
    logic signed [COORD_W-1:0] start_reg [DIV_STEPS];
    div_state_t                st_zero;
    logic signed [QUO_W:0]     off;
    logic signed [RES_W-1:0]   sum;

    // remainder stays below den, so one step adds at most two to the quotient
    function automatic div_state_t div_step(div_state_t s, logic b, div_ctl_t c);
        div_state_t       o;
        logic [MAG_W-1:0] t;
        logic [MAG_W-1:0] den2;
        t    = {s.r[MAG_W-2:0], 1'b0} + (b ? c.m1 : '0);
        den2 = {c.den[MAG_W-2:0], 1'b0};
        o.q  = {s.q[QUO_W-2:0], 1'b0};
        if (t >= den2)
        begin
            o.r = t - den2;
            o.q = o.q + QUO_W'(2);
        end
        else if (t >= c.den)
        begin
            o.r = t - c.den;
            o.q = o.q + QUO_W'(1);
        end
        else
        begin
            o.r = t;
        end
        return o;
    endfunction

    assign st_zero = '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]    <= div_step(st_zero, delta.mag[DELTA_W-1], ctl);
            bits_reg[0]  <= {delta.mag[DELTA_W-2:0], 1'b0};
            ctl_reg[0]   <= ctl;
            neg_reg[0]   <= delta.neg;
            start_reg[0] <= delta.start;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                st_reg[k]    <= div_step(st_reg[k-1], bits_reg[k-1][DELTA_W-1], ctl_reg[k-1]);
                bits_reg[k]  <= {bits_reg[k-1][DELTA_W-2:0], 1'b0};
                ctl_reg[k]   <= ctl_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                start_reg[k] <= start_reg[k-1];
            end
        end
    end

    always_comb
    begin
        off = neg_reg[DIV_STEPS-1] ? -$signed({1'b0, st_reg[DIV_STEPS-1].q})
                                   :  $signed({1'b0, st_reg[DIV_STEPS-1].q});
        sum = RES_W'(start_reg[DIV_STEPS-1]) + RES_W'(off);
        if (sum > SAT_HI)
        begin
            coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (sum < SAT_LO)
        begin
            coord = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            coord = sum[COORD_W-1:0];
        end
    end

    assign start = start_reg[DIV_STEPS-1];

endmodule

>>> hw/rtl/segment_hyperplane_intersect_core.sv
// ----------------------------------------------------------------------------
// segment_hyperplane_intersect_core
// Tests a 4D segment against the hyperplane Ax+By+Cz+Dw+E (Q16.16) and gives
// the crossing flag, degenerate flag and intersection point.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes plane_a..e
//   at index 0..4; other indexes are ignored. cfg_ready is always high.
//   Write only while no item is in flight.
//   in channel carries one segment per item, out channel one result per item.
//   Pipeline: 1 product stage, 3 side-sum/classify stages, 33 division stages
//   and 1 output register. Throughput: one item per cycle while out_ready
//   does not hold the pipeline; every stage is pipelined, including the
//   33-stage per-lane divider that takes one bit of the difference per stage.
//   Four coordinate lanes run side by side; a merge stage forms the side
//   values shared by all lanes.
//   When out_ready is low with a result waiting, the whole pipeline holds and
//   in_ready drops; bubbles inside the pipeline are not squeezed out.
//   Reset clears the plane registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module segment_hyperplane_intersect_core
    import shi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    logic signed [COORD_W-1:0] coef_reg [NUM_LANES];
    logic signed [COORD_W-1:0] plane_e_reg;
    logic                      valid_reg [PIPE_DEPTH];
    logic                      valid_tail;
    cross_flags_t              flags_dly_reg [DIV_STEPS];
    out_item_t                 out_reg;
    out_item_t                 out_next;
    logic                      out_valid_reg;
    logic                      adv;
    logic                      any_valid;
    logic signed [COORD_W-1:0] p_start [NUM_LANES];
    logic signed [COORD_W-1:0] p_end   [NUM_LANES];
    side_prod_t                prod    [NUM_LANES];
    seg_delta_t                delta   [NUM_LANES];
    logic signed [COORD_W-1:0] coord   [NUM_LANES];
    logic signed [COORD_W-1:0] start   [NUM_LANES];
    logic signed [COORD_W-1:0] res     [NUM_LANES];
    cross_flags_t              flags;
    div_ctl_t                  ctl;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    assign p_start[0] = in_data.start_x;
    assign p_start[1] = in_data.start_y;
    assign p_start[2] = in_data.start_z;
    assign p_start[3] = in_data.start_w;
    assign p_end[0]   = in_data.end_x;
    assign p_end[1]   = in_data.end_y;
    assign p_end[2]   = in_data.end_z;
    assign p_end[3]   = in_data.end_w;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                coef_reg[k] <= '0;
            end
            plane_e_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLANE_A: coef_reg[0]  <= cfg_data;
                REG_PLANE_B: coef_reg[1]  <= cfg_data;
                REG_PLANE_C: coef_reg[2]  <= cfg_data;
                REG_PLANE_D: coef_reg[3]  <= cfg_data;
                REG_PLANE_E: plane_e_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        shi_side_lane u_side (
            .clk     (clk),
            .en      (adv),
            .coef    (coef_reg[g]),
            .p_start (p_start[g]),
            .p_end   (p_end[g]),
            .prod    (prod[g]),
            .delta   (delta[g])
        );

        shi_div_lane u_div (
            .clk   (clk),
            .en    (adv),
            .delta (delta[g]),
            .ctl   (ctl),
            .coord (coord[g]),
            .start (start[g])
        );

        always_comb
        begin
            if (!flags_dly_reg[DIV_STEPS-1].crosses)
            begin
                res[g] = '0;
            end
            else if (flags_dly_reg[DIV_STEPS-1].degenerate)
            begin
                res[g] = start[g];
            end
            else
            begin
                res[g] = coord[g];
            end
        end
    end

    shi_plane_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .en      (adv),
        .prod    (prod),
        .plane_e (plane_e_reg),
        .flags   (flags),
        .ctl     (ctl)
    );

    // item valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_dly_reg[0] <= flags;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                flags_dly_reg[k] <= flags_dly_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next.crosses    = flags_dly_reg[DIV_STEPS-1].crosses;
        out_next.degenerate = flags_dly_reg[DIV_STEPS-1].degenerate;
        out_next.cross_x    = res[0];
        out_next.cross_y    = res[1];
        out_next.cross_z    = res[2];
        out_next.cross_w    = res[3];
    end

    always_comb
    begin
        any_valid = 1'b0;
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            any_valid = any_valid | valid_reg[k];
        end
    end

    assign valid_tail = valid_reg[PIPE_DEPTH-1];
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

`ifndef NO_ASSERTIONS
    a_degen_implies_cross: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |-> out_data.crosses)
        else $error("degenerate result without crossing");

    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.crosses |-> out_data.cross_x == '0 &&
        out_data.cross_y == '0 && out_data.cross_z == '0 && out_data.cross_w == '0)
        else $error("non-crossing result with nonzero point");

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && valid_tail |=> valid_tail)
        else $error("pipeline tail lost during output stall");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !any_valid && !out_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> sim/tb_segment_hyperplane_intersect_core.sv
// ----------------------------------------------------------------------------
// tb_segment_hyperplane_intersect_core
// Self-checking bench for the 4D segment / hyperplane intersection core: plane
// registers are written between phases, segments stream in with random gaps
// and output stalls, and each result is compared with a wide-integer predictor.
// ----------------------------------------------------------------------------
class crossing_board;
    shi_pkg::out_item_t pending[$];
    int                 errors;
    int                 n_checked;
    int                 n_crossing;
    int                 n_degenerate;

    function void note_segment(shi_pkg::out_item_t exp_item);
        pending = {pending, exp_item};
    endfunction

    function void check_result(shi_pkg::out_item_t got);
        shi_pkg::out_item_t exp_item;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
        end
        exp_item = pending.pop_front();
        n_checked++;
        if (got.crosses)
            n_crossing++;
        if (got.degenerate)
            n_degenerate++;
        if (got.crosses !== exp_item.crosses)
        begin
            $display("%0t: crosses exp %b got %b", $realtime, exp_item.crosses, got.crosses);
            errors++;
        end
        if (got.degenerate !== exp_item.degenerate)
        begin
            $display("%0t: degenerate exp %b got %b", $realtime, exp_item.degenerate,
                     got.degenerate);
            errors++;
        end
        if (got.cross_x !== exp_item.cross_x)
        begin
            $display("%0t: cross_x exp %h got %h", $realtime, exp_item.cross_x, got.cross_x);
            errors++;
        end
        if (got.cross_y !== exp_item.cross_y)
        begin
            $display("%0t: cross_y exp %h got %h", $realtime, exp_item.cross_y, got.cross_y);
            errors++;
        end
        if (got.cross_z !== exp_item.cross_z)
        begin
            $display("%0t: cross_z exp %h got %h", $realtime, exp_item.cross_z, got.cross_z);
            errors++;
        end
        if (got.cross_w !== exp_item.cross_w)
        begin
            $display("%0t: cross_w exp %h got %h", $realtime, exp_item.cross_w, got.cross_w);
            errors++;
        end
    endfunction
endclass

module tb_segment_hyperplane_intersect_core;
    import shi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;

    logic signed [31:0]   plane [5];
    crossing_board        board;
    int                   hold_off = 0;
    int                   out_gap = 0;
    bit                   streaming = 1'b0;

    segment_hyperplane_intersect_core #(.FRAC_BITS(FRAC)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [127:0] plane_side(logic signed [31:0] px,
        logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] pw);
        logic signed [127:0] s;
        s = 128'(plane[4]) <<< FRAC;
        s = s + 128'(plane[0]) * 128'(px) + 128'(plane[1]) * 128'(py)
              + 128'(plane[2]) * 128'(pz) + 128'(plane[3]) * 128'(pw);
        return s;
    endfunction

    function automatic logic signed [31:0] lerp_coord(logic signed [31:0] p1,
        logic signed [31:0] p2, logic [127:0] m1, logic [127:0] den);
        logic signed [63:0] d;
        logic [127:0]       q;
        logic signed [63:0] r;
        d = 64'(p2) - 64'(p1);
        q = ((d < 0) ? 128'(-d) : 128'(d)) * m1 / den;
        if (q > 128'h3FFF_FFFF_FFFF)
            q = 128'h3FFF_FFFF_FFFF;
        r = 64'(p1) + ((d < 0) ? -$signed(64'(q)) : $signed(64'(q)));
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic out_item_t predict_crossing(in_item_t seg);
        out_item_t           res;
        logic signed [127:0] s1;
        logic signed [127:0] s2;
        logic [127:0]        m1;
        logic [127:0]        den;
        res = '0;
        s1 = plane_side(seg.start_x, seg.start_y, seg.start_z, seg.start_w);
        s2 = plane_side(seg.end_x, seg.end_y, seg.end_z, seg.end_w);
        if ((s1 >= 0) == (s2 > 0))
            return res;
        res.crosses = 1'b1;
        m1 = (s1 < 0) ? -s1 : s1;
        den = m1 + ((s2 < 0) ? -s2 : s2);
        if (den == 0)
        begin
            res.degenerate = 1'b1;
            res.cross_x = seg.start_x;
            res.cross_y = seg.start_y;
            res.cross_z = seg.start_z;
            res.cross_w = seg.start_w;
            return res;
        end
        res.cross_x = lerp_coord(seg.start_x, seg.end_x, m1, den);
        res.cross_y = lerp_coord(seg.start_y, seg.end_y, m1, den);
        res.cross_z = lerp_coord(seg.start_z, seg.end_z, m1, den);
        res.cross_w = lerp_coord(seg.start_w, seg.end_w, m1, den);
        return res;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            3: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_plane(cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        plane[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_unknown(logic [CFG_IDX_W-1:0] idx);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= $urandom;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4)
            @(posedge clk);
    endtask

    task automatic send_segment(in_item_t seg, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= seg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_segment(predict_crossing(seg));
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t rand_segment();
        in_item_t seg;
        seg.start_x = rand_coord();
        seg.start_y = rand_coord();
        seg.start_z = rand_coord();
        seg.start_w = rand_coord();
        seg.end_x = rand_coord();
        seg.end_y = rand_coord();
        seg.end_z = rand_coord();
        seg.end_w = rand_coord();
        if ($urandom_range(0, 7) == 0)
            seg.end_x = seg.start_x;
        return seg;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_segment(rand_segment(), 1'b1);
        end_burst();
    endtask

    always @(posedge clk)
    begin : receiver
        int wait_draw;
        wait_draw = $urandom_range(0, 3);
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (streaming && out_valid && out_ready)
        begin
            out_gap   <= wait_draw;
            out_ready <= (wait_draw == 0);
        end
        else if (out_gap > 1)
            out_gap <= out_gap - 1;
        else
        begin
            out_gap   <= 0;
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_segment_hyperplane_intersect_core: done, errors");
        $finish;
    end

    initial
    begin
        in_item_t seg;
        board = new();
        foreach (plane[i])
            plane[i] = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero plane: every point sits on it, degenerate crossing
        seg = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h10000};
        send_segment(seg, 1'b0);
        end_burst();
        drain();

        // plane x = 0
        write_plane(REG_PLANE_A, 32'h0001_0000);
        write_plane(REG_PLANE_B, 32'h0);
        write_plane(REG_PLANE_C, 32'h0);
        write_plane(REG_PLANE_D, 32'h0);
        write_plane(REG_PLANE_E, 32'h0);
        write_unknown(3'd5);
        write_unknown(3'd7);
        send_segment('{-32'sh10000, 1, 2, 3, 32'sh30000, 5, 6, 7}, 1'b0);
        send_segment('{32'sh10000, 1, 2, 3, -32'sh30000, 5, 6, 7}, 1'b0);
        send_segment('{0, 9, 9, 9, -32'sh10000, 1, 1, 1}, 1'b0);
        send_segment('{-32'sh10000, 9, 9, 9, 0, 1, 1, 1}, 1'b0);
        send_segment('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0);
        send_segment('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0);
        send_segment('{5, 5, 5, 5, 7, 7, 7, 7}, 1'b0);
        end_burst();
        drain();

        // extreme coefficients
        write_plane(REG_PLANE_A, 32'h8000_0000);
        write_plane(REG_PLANE_B, 32'h7FFF_FFFF);
        write_plane(REG_PLANE_C, 32'h8000_0000);
        write_plane(REG_PLANE_D, 32'h7FFF_FFFF);
        write_plane(REG_PLANE_E, 32'h8000_0000);
        send_segment('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0);
        send_segment('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0);
        send_segment('{0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF}, 1'b0);
        end_burst();
        drain();

        // random phases with new planes between them
        streaming = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_plane(REG_PLANE_A, rand_coord());
            write_plane(REG_PLANE_B, (ph == 1) ? 32'h0 : rand_coord());
            write_plane(REG_PLANE_C, rand_coord());
            write_plane(REG_PLANE_D, (ph == 2) ? 32'h0 : rand_coord());
            write_plane(REG_PLANE_E, ($urandom_range(0, 1)) ? 32'h0 : rand_coord());
            if (ph == 3)
                hold_off = 120;
            random_phase(90);
            drain();
        end
        streaming = 1'b0;

        $display("checked %0d results: %0d crossings, %0d degenerate, 9 plane settings",
                 board.n_checked, board.n_crossing, board.n_degenerate);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_segment_hyperplane_intersect_core: done, clean");
        else
            $display("tb_segment_hyperplane_intersect_core: done, errors");
        $finish;
    end
endmodule
